>>> rtl/spwm_pkg.sv
// Package for the sinusoidal PWM duty generator: word types, register and mode codes,
// default parameter values and duty scaling constants.
// No dependencies.
package spwm_pkg;

	localparam int DEF_SINE_STEPS  = 1024;
	localparam int DEF_COUNT_WIDTH = 16;

	localparam int DUTY_W = 16;
	localparam int CFG_W  = 16;

	// duty = floor(top * (HALF + amp*s) / DIV), DIV = 100 * 2^16
	localparam logic signed [23:0] DUTY_HALF = 24'sd3276800;
	localparam logic signed [23:0] DUTY_DIV  = 24'sd6553600;

	localparam logic [1:0] MODE_FOUR = 2'd1;
	localparam logic [1:0] MODE_PAIR = 2'd2;

	localparam logic [1:0]  RST_MODE = 2'd0;
	localparam logic [7:0]  RST_FMUL = 8'd1;
	localparam logic [6:0]  RST_AMP  = 7'd0;
	localparam logic [15:0] RST_TOP  = 16'd1024;

	typedef enum logic [1:0] {
		REG_MODE = 2'd0,
		REG_FMUL = 2'd1,
		REG_AMP  = 2'd2,
		REG_TOP  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic tick;
	} tick_word_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_ch1;
		logic [DUTY_W-1:0] duty_ch2;
		logic [DUTY_W-1:0] duty_ch3;
		logic [DUTY_W-1:0] duty_ch4;
		logic              upper_valid;
	} duty_word_t;

	typedef struct packed {
		cfg_reg_t         index;
		logic [CFG_W-1:0] wdata;
	} cfg_word_t;

endpackage

>>> rtl/spwm_chan_if.sv
// Valid/ready channel carrying one word of a given type.
// Used for the tick, duty and configuration channels; word types come from spwm_pkg.
interface spwm_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/spwm_modmul.sv
// Bit-serial modular multiplier: x * y mod MODULUS, one multiplier bit per cycle, MSB first.
// Standalone; no package needed.
module spwm_modmul #(
	parameter int MODULUS = 1024,
	parameter int N       = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [$clog2(MODULUS)-1:0] x,
	input  logic [N-1:0]               y,
	output logic [$clog2(MODULUS)-1:0] res,
	output logic                       done
);
	localparam int PW = $clog2(MODULUS);
	localparam int CW = $clog2(N + 1);
	localparam logic [PW+1:0] MOD1 = (PW+2)'(MODULUS);
	localparam logic [PW+1:0] MOD2 = (PW+2)'(2 * MODULUS);

	logic [PW-1:0] acc_q;
	logic [PW-1:0] x_q;
	logic [N-1:0]  y_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [PW+1:0] t;
	logic [PW+1:0] t_red;

	always_comb begin
		t = {1'b0, acc_q, 1'b0} + (y_q[N-1] ? {2'b00, x_q} : '0);
		if (t >= MOD2) begin
			t_red = t - MOD2;
		end else if (t >= MOD1) begin
			t_red = t - MOD1;
		end else begin
			t_red = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1)) && !start;
			if (start) begin
				cnt_q <= CW'(N);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (cnt_q != '0) begin
			acc_q <= t_red[PW-1:0];
			y_q   <= y_q << 1;
		end
	end

	assign res  = acc_q;
	assign done = done_q;

endmodule

>>> rtl/spwm_sine_rom.sv
// Quarter-wave Q1.15 sine table with quadrant folding and registered read.
// Table is built at elaboration; no package needed.
module spwm_sine_rom #(
	parameter int SINE_STEPS = 1024
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [$clog2(SINE_STEPS)-1:0] p,
	output logic signed [15:0]            s
);
	localparam int PW      = $clog2(SINE_STEPS);
	localparam int QUARTER = SINE_STEPS / 4;
	localparam int IW      = $clog2(QUARTER + 1);
	localparam logic [PW:0] Q1 = (PW+1)'(QUARTER);
	localparam logic [PW:0] Q2 = (PW+1)'(2 * QUARTER);
	localparam logic [PW:0] Q3 = (PW+1)'(3 * QUARTER);
	localparam logic [PW:0] Q4 = (PW+1)'(4 * QUARTER);
	localparam longint PI_Q30 = 64'sd3373259426;

	// sin(2*pi*k/SINE_STEPS), Q30 Taylor series to the 25th power, rounded to Q15
	function automatic logic [14:0] quarter_sine(input int k);
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint r;
		x    = (longint'(k) * PI_Q30 * 64'sd2) / SINE_STEPS;
		x2   = (x * x) >>> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >>> 30) / 64'sd6;
		sum  = sum - term;
		term = ((term * x2) >>> 30) / 64'sd20;
		sum  = sum + term;
		term = ((term * x2) >>> 30) / 64'sd42;
		sum  = sum - term;
		term = ((term * x2) >>> 30) / 64'sd72;
		sum  = sum + term;
		term = ((term * x2) >>> 30) / 64'sd110;
		sum  = sum - term;
		term = ((term * x2) >>> 30) / 64'sd156;
		sum  = sum + term;
		term = ((term * x2) >>> 30) / 64'sd210;
		sum  = sum - term;
		term = ((term * x2) >>> 30) / 64'sd272;
		sum  = sum + term;
		term = ((term * x2) >>> 30) / 64'sd342;
		sum  = sum - term;
		term = ((term * x2) >>> 30) / 64'sd420;
		sum  = sum + term;
		term = ((term * x2) >>> 30) / 64'sd506;
		sum  = sum - term;
		term = ((term * x2) >>> 30) / 64'sd600;
		sum  = sum + term;
		if (sum < 0) begin
			sum = 0;
		end
		r = (sum + 64'sd16384) >>> 15;
		if (r > 32767) begin
			r = 32767;
		end
		return r[14:0];
	endfunction

	logic [14:0]   rom_tbl [QUARTER+1];
	logic [PW:0]   pe;
	logic [PW:0]   fold;
	logic          neg;
	logic [14:0]   rom_s1;
	logic          neg_s1;

	for (genvar k = 0; k <= QUARTER; k++) begin : g_tbl
		assign rom_tbl[k] = quarter_sine(k);
	end

	always_comb begin
		pe = {1'b0, p};
		if (pe <= Q1) begin
			fold = pe;
			neg  = 1'b0;
		end else if (pe <= Q2) begin
			fold = Q2 - pe;
			neg  = 1'b0;
		end else if (pe <= Q3) begin
			fold = pe - Q2;
			neg  = 1'b1;
		end else begin
			fold = Q4 - pe;
			neg  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rom_s1 <= rom_tbl[fold[IW-1:0]];
			neg_s1 <= neg;
		end
	end

	assign s = neg_s1 ? -$signed({1'b0, rom_s1}) : $signed({1'b0, rom_s1});

endmodule

>>> rtl/spwm_duty_div.sv
// Duty unit: floor(top * (HALF + amp*s) / DIV), clamped to 0..top.
// Serial over the bits of top with a running quotient and remainder; uses spwm_pkg.
module spwm_duty_div
	import spwm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DUTY_W-1:0]        top,
	input  logic [6:0]               amp,
	input  logic signed [15:0]       s,
	output logic [DUTY_W-1:0]        duty,
	output logic                     done
);
	localparam int CW = $clog2(DUTY_W + 1);
	localparam logic [24:0] D1 = 25'(DUTY_DIV);
	localparam logic [24:0] D2 = 25'(2 * DUTY_DIV);

	logic signed [23:0] m_prod;
	logic signed [23:0] m_q;
	logic [DUTY_W-1:0]  top_q;
	logic [DUTY_W-1:0]  tsh_q;
	logic [22:0]        r_q;
	logic [DUTY_W-1:0]  q_q;
	logic [CW-1:0]      cnt_q;
	logic               done_q;
	logic               in_range;
	logic [22:0]        mm;
	logic [24:0]        t;
	logic [24:0]        t_red;
	logic [1:0]         c;

	assign m_prod = $signed({1'b0, amp}) * s;

	always_comb begin
		in_range = (m_q > 24'sd0) && (m_q < DUTY_DIV);
		mm       = in_range ? m_q[22:0] : '0;
		t        = {1'b0, r_q, 1'b0} + (tsh_q[DUTY_W-1] ? {2'b00, mm} : '0);
		if (t >= D2) begin
			t_red = t - D2;
			c     = 2'd2;
		end else if (t >= D1) begin
			t_red = t - D1;
			c     = 2'd1;
		end else begin
			t_red = t;
			c     = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1)) && !start;
			if (start) begin
				cnt_q <= CW'(DUTY_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= m_prod + DUTY_HALF;
			top_q <= top;
			tsh_q <= top;
			r_q   <= '0;
			q_q   <= '0;
		end else if (cnt_q != '0) begin
			r_q   <= t_red[22:0];
			q_q   <= {q_q[DUTY_W-2:0], 1'b0} + DUTY_W'(c);
			tsh_q <= tsh_q << 1;
		end
	end

	always_comb begin
		if (m_q <= 24'sd0) begin
			duty = '0;
		end else if (m_q >= DUTY_DIV) begin
			duty = top_q;
		end else begin
			duty = q_q;
		end
	end

	assign done = done_q;

endmodule

>>> rtl/sine_pwm_duty_generator.sv
// Sinusoidal PWM duty generator, top level. An active tick goes through two serial passes
// of the phase multiplier, the registered sine ROM read and the serial duty divide, then
// waits in ST_HOLD for a free output slot; ticks are taken only in idle, so none is taken until then.
// Ticks in idle modes or with the tick bit low are taken without leaving idle and give no word.
// arst_n clears the phase counter, sequencer and output valid; config registers take reset values.
// Uses spwm_pkg, spwm_chan_if, spwm_modmul, spwm_sine_rom and spwm_duty_div.
module sine_pwm_duty_generator
	import spwm_pkg::*;
#(
	parameter int SINE_STEPS  = DEF_SINE_STEPS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	spwm_chan_if.sink   ticks,
	spwm_chan_if.source duties,
	spwm_chan_if.sink   cfg
);
	localparam int PW = $clog2(SINE_STEPS);
	localparam logic [PW-1:0] STEP60 = PW'(60 % SINE_STEPS);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MULA = 6'b000010,
		ST_MULP = 6'b000100,
		ST_ROM  = 6'b001000,
		ST_DUTY = 6'b010000,
		ST_HOLD = 6'b100000
	} state_t;

	state_t               state_q;
	logic [1:0]           mode_q;
	logic [7:0]           fmul_q;
	logic [6:0]           amp_q;
	logic [DUTY_W-1:0]    top_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic                 out_v_q;
	duty_word_t           out_q;

	logic                 tick_acc;
	logic                 active;
	logic                 slot_free;
	logic                 mm_start;
	logic [PW-1:0]        mm_x;
	logic [COUNT_WIDTH-1:0] mm_y;
	logic [PW-1:0]        mm_res;
	logic                 mm_done;
	logic                 rom_en;
	logic signed [15:0]   sine;
	logic signed [15:0]   sine_neg;
	logic                 du_start;
	logic [DUTY_W-1:0]    duty_a;
	logic [DUTY_W-1:0]    duty_b;
	logic                 du_done_a;
	logic                 du_done_b;

	assign cfg.ready   = 1'b1;
	assign ticks.ready = (state_q == ST_IDLE);
	assign tick_acc    = ticks.valid && ticks.ready;
	assign active      = ticks.data.tick && (mode_q == MODE_FOUR || mode_q == MODE_PAIR);
	assign count_inc   = count_q + COUNT_WIDTH'(1);
	assign slot_free   = !out_v_q || duties.ready;

	assign mm_start = (tick_acc && active) || ((state_q == ST_MULA) && mm_done);
	assign mm_x     = (state_q == ST_MULA) ? mm_res : STEP60;
	assign mm_y     = (state_q == ST_MULA) ? count_q : COUNT_WIDTH'(fmul_q);
	assign rom_en   = (state_q == ST_MULP) && mm_done;
	assign du_start = (state_q == ST_ROM);
	assign sine_neg = -sine;

	spwm_modmul #(
		.MODULUS (SINE_STEPS),
		.N       (COUNT_WIDTH)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.x      (mm_x),
		.y      (mm_y),
		.res    (mm_res),
		.done   (mm_done)
	);

	spwm_sine_rom #(
		.SINE_STEPS (SINE_STEPS)
	) u_sine_rom (
		.clk (clk),
		.en  (rom_en),
		.p   (mm_res),
		.s   (sine)
	);

	spwm_duty_div u_duty_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (du_start),
		.top    (top_q),
		.amp    (amp_q),
		.s      (sine),
		.duty   (duty_a),
		.done   (du_done_a)
	);

	spwm_duty_div u_duty_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (du_start),
		.top    (top_q),
		.amp    (amp_q),
		.s      (sine_neg),
		.duty   (duty_b),
		.done   (du_done_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RST_MODE;
			fmul_q <= RST_FMUL;
			amp_q  <= RST_AMP;
			top_q  <= RST_TOP;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				REG_MODE: mode_q <= cfg.data.wdata[1:0];
				REG_FMUL: fmul_q <= cfg.data.wdata[7:0];
				REG_AMP:  amp_q  <= cfg.data.wdata[6:0];
				REG_TOP:  top_q  <= cfg.data.wdata[DUTY_W-1:0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_acc && active) begin
						count_q <= (16'(count_inc) >= top_q) ? '0 : count_inc;
						state_q <= ST_MULA;
					end
				end
				ST_MULA: begin
					if (mm_done) begin
						state_q <= ST_MULP;
					end
				end
				ST_MULP: begin
					if (mm_done) begin
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					state_q <= ST_DUTY;
				end
				ST_DUTY: begin
					if (du_done_a && du_done_b) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((state_q == ST_HOLD) && slot_free) begin
			out_v_q <= 1'b1;
		end else if (duties.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_HOLD) && slot_free) begin
			out_q.duty_ch1 <= duty_a;
			if (mode_q == MODE_FOUR) begin
				out_q.duty_ch2    <= duty_a;
				out_q.duty_ch3    <= duty_a;
				out_q.duty_ch4    <= duty_a;
				out_q.upper_valid <= 1'b1;
			end else begin
				out_q.duty_ch2    <= duty_b;
				out_q.duty_ch3    <= '0;
				out_q.duty_ch4    <= '0;
				out_q.upper_valid <= 1'b0;
			end
		end
	end

	assign duties.valid = out_v_q;
	assign duties.data  = out_q;

endmodule

>>> rtl/spwm_checker.sv
// Port-level checks for sine_pwm_duty_generator, attached by the bind at the end.
// Uses spwm_pkg for the duty word type.
module spwm_checker
	import spwm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       tick_valid,
	input logic       tick_ready,
	input logic       res_valid,
	input logic       res_ready,
	input duty_word_t res_word
);

	// a word is never produced straight after a tick is taken
	a_no_early_word: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && tick_ready) |=> !$rose(res_valid))
		else $error("duty word rose right after a tick");

	a_pair_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_word.upper_valid) |->
		(res_word.duty_ch3 == '0 && res_word.duty_ch4 == '0))
		else $error("channels 3/4 non-zero in pair mode");

	a_four_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_word.upper_valid) |->
		(res_word.duty_ch2 == res_word.duty_ch1 && res_word.duty_ch3 == res_word.duty_ch1 &&
		 res_word.duty_ch4 == res_word.duty_ch1))
		else $error("four-channel word with unequal duties");

	a_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_word)))
		else $error("stalled duty word dropped or changed");

endmodule

bind sine_pwm_duty_generator spwm_checker u_spwm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (ticks.valid),
	.tick_ready (ticks.ready),
	.res_valid  (duties.valid),
	.res_ready  (duties.ready),
	.res_word   (duties.data)
);

>>> verif/spwm_duty_checker.sv
`timescale 1ns / 100ps
// Duty checker for the sinusoidal PWM generator: follows the register writes and the ticks,
// predicts each duty word and compares it with the words leaving the block.
// Depends on spwm_pkg.
module spwm_duty_checker
	import spwm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tick_valid,
	input  logic       tick_ready,
	input  tick_word_t tick_data,
	input  logic       duty_valid,
	input  logic       duty_ready,
	input  duty_word_t duty_data,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  cfg_word_t  cfg_data,
	output int         fails,
	output int         pending
);

	localparam int     STEPS      = DEF_SINE_STEPS;
	localparam int     QUARTER    = STEPS / 4;
	localparam longint PI_Q30     = 64'sd3373259426;
	localparam longint HALF_SCALE = 64'sd3276800;
	localparam longint FULL_SCALE = 64'sd6553600;
	localparam int     MAX_REPORT = 10;

	int          sine_lut [0:QUARTER];
	logic [1:0]  mode_q;
	logic [7:0]  fmul_q;
	logic [6:0]  amp_q;
	logic [15:0] top_q;
	logic [15:0] phase_q;
	duty_word_t  duty_q [$];
	duty_word_t  exp_w;
	int          fail_cnt = 0;
	int          idx;
	int          s;

	// quarter-wave table, Q30 Taylor series rounded to Q15
	initial begin
		longint x, x2, term, acc, r;
		int k, n;
		for (k = 0; k <= QUARTER; k++) begin
			x = (longint'(k) * PI_Q30 * 2) / STEPS;
			x2 = (x * x) >>> 30;
			term = x;
			acc = x;
			for (n = 1; n <= 12; n++) begin
				term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			r = (acc + (64'sd1 <<< 14)) >>> 15;
			if (r > 32767) begin
				r = 32767;
			end
			sine_lut[k] = int'(r);
		end
	end

	function automatic logic [15:0] duty_for(int sv);
		longint top, num, d;
		top = longint'(top_q);
		num = top * HALF_SCALE + top * longint'(amp_q) * longint'(sv);
		if (num <= 0) begin
			return 16'd0;
		end
		d = num / FULL_SCALE;
		if (d > top) begin
			d = top;
		end
		return 16'(d);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  = 2'd0;
			fmul_q  = 8'd1;
			amp_q   = 7'd0;
			top_q   = 16'd1024;
			phase_q = 16'd0;
			duty_q.delete();
		end else begin
			if (duty_valid && duty_ready) begin
				if (duty_q.size() == 0) begin
					if (fail_cnt < MAX_REPORT) begin
						$display("duty word with none expected: ch1=%0d ch2=%0d ch3=%0d ch4=%0d up=%0b",
							duty_data.duty_ch1, duty_data.duty_ch2, duty_data.duty_ch3,
							duty_data.duty_ch4, duty_data.upper_valid);
					end
					fail_cnt++;
				end else begin
					exp_w = duty_q.pop_front();
					if (duty_data.duty_ch1 !== exp_w.duty_ch1 || duty_data.duty_ch2 !== exp_w.duty_ch2 ||
						duty_data.duty_ch3 !== exp_w.duty_ch3 || duty_data.duty_ch4 !== exp_w.duty_ch4 ||
						duty_data.upper_valid !== exp_w.upper_valid) begin
						if (fail_cnt < MAX_REPORT) begin
							$display("duty mismatch: exp %0d %0d %0d %0d up=%0b, got %0d %0d %0d %0d up=%0b",
								exp_w.duty_ch1, exp_w.duty_ch2, exp_w.duty_ch3, exp_w.duty_ch4,
								exp_w.upper_valid, duty_data.duty_ch1, duty_data.duty_ch2,
								duty_data.duty_ch3, duty_data.duty_ch4, duty_data.upper_valid);
						end
						fail_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_MODE: mode_q = cfg_data.wdata[1:0];
					REG_FMUL: fmul_q = cfg_data.wdata[7:0];
					REG_AMP:  amp_q  = cfg_data.wdata[6:0];
					REG_TOP:  top_q  = cfg_data.wdata[15:0];
					default: ;
				endcase
			end
			if (tick_valid && tick_ready && tick_data.tick &&
				(mode_q == MODE_FOUR || mode_q == MODE_PAIR)) begin
				phase_q = phase_q + 16'd1;
				if (phase_q >= top_q) begin
					phase_q = 16'd0;
				end
				idx = int'((longint'(fmul_q) * 60 * longint'(phase_q)) % STEPS);
				if (idx <= QUARTER) begin
					s = sine_lut[idx];
				end else if (idx <= 2 * QUARTER) begin
					s = sine_lut[2 * QUARTER - idx];
				end else if (idx <= 3 * QUARTER) begin
					s = -sine_lut[idx - 2 * QUARTER];
				end else begin
					s = -sine_lut[4 * QUARTER - idx];
				end
				if (mode_q == MODE_FOUR) begin
					exp_w.duty_ch1    = duty_for(s);
					exp_w.duty_ch2    = exp_w.duty_ch1;
					exp_w.duty_ch3    = exp_w.duty_ch1;
					exp_w.duty_ch4    = exp_w.duty_ch1;
					exp_w.upper_valid = 1'b1;
				end else begin
					exp_w.duty_ch1    = duty_for(s);
					exp_w.duty_ch2    = duty_for(-s);
					exp_w.duty_ch3    = 16'd0;
					exp_w.duty_ch4    = 16'd0;
					exp_w.upper_valid = 1'b0;
				end
				duty_q.push_back(exp_w);
			end
		end
		pending <= duty_q.size();
		fails   <= fail_cnt;
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for sine_pwm_duty_generator: clock, reset, register writes, tick stimulus,
// duty back-pressure and the verdict. Depends on spwm_pkg, spwm_chan_if, spwm_duty_checker.
module tb_top;
	import spwm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 60;
	localparam int PHASES      = 10;
	localparam int PHASE_WORDS = 40;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int unsigned cycles = 0;
	int  fails;
	int  pending;
	bit  calm     = 1'b0;
	bit  hold_req = 1'b0;

	spwm_chan_if #(.word_t(tick_word_t)) ticks_if ();
	spwm_chan_if #(.word_t(duty_word_t)) duty_if ();
	spwm_chan_if #(.word_t(cfg_word_t))  cfg_if ();

	sine_pwm_duty_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.ticks  (ticks_if),
		.duties (duty_if),
		.cfg    (cfg_if)
	);

	spwm_duty_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (ticks_if.valid),
		.tick_ready (ticks_if.ready),
		.tick_data  (ticks_if.data),
		.duty_valid (duty_if.valid),
		.duty_ready (duty_if.ready),
		.duty_data  (duty_if.data),
		.cfg_valid  (cfg_if.valid),
		.cfg_ready  (cfg_if.ready),
		.cfg_data   (cfg_if.data),
		.fails      (fails),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// duty sink: random back-pressure, long hold-off on request
	initial begin
		duty_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				duty_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				duty_if.ready <= calm || ($urandom_range(99) >= 27);
			end
		end
	end

	task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= '{index: r, wdata: v};
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	task automatic set_regs(input logic [3:0] sel, input logic [1:0] m, input logic [7:0] f,
		input logic [6:0] a, input logic [15:0] t);
		logic [15:0] v;
		if (sel[REG_MODE]) begin
			v = $urandom_range(1) ? 16'($urandom) : 16'd0;
			v[1:0] = m;
			write_reg(REG_MODE, v);
		end
		if (sel[REG_FMUL]) begin
			v = $urandom_range(1) ? 16'($urandom) : 16'd0;
			v[7:0] = f;
			write_reg(REG_FMUL, v);
		end
		if (sel[REG_AMP]) begin
			v = $urandom_range(1) ? 16'($urandom) : 16'd0;
			v[6:0] = a;
			write_reg(REG_AMP, v);
		end
		if (sel[REG_TOP]) begin
			write_reg(REG_TOP, t);
		end
		cfg_if.valid <= 1'b0;
	endtask

	task automatic send_tick(input logic t);
		ticks_if.valid <= 1'b1;
		ticks_if.data  <= '{tick: t};
		do @(posedge clk); while (!ticks_if.ready);
	endtask

	task automatic sender_gap();
		if (!calm && $urandom_range(99) < 27) begin
			ticks_if.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	// wait for every expected word, then let a tick that gives no word finish
	task automatic await_drained(input bit settle);
		ticks_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		if (settle) begin
			repeat (SETTLE) @(posedge clk);
		end
	endtask

	function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
		int unsigned r;
		r = $urandom_range(9);
		if (r < 2) begin
			return lo;
		end
		if (r < 4) begin
			return hi;
		end
		return $urandom_range(hi, lo);
	endfunction

	initial begin
		logic [1:0]  m;
		logic [7:0]  f;
		logic [6:0]  a;
		logic [15:0] t;
		logic        tk;
		int          ph, sent, counted, r;
		bit          active;

		ticks_if.valid <= 1'b0;
		ticks_if.data  <= '0;
		cfg_if.valid   <= 1'b0;
		cfg_if.data    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// idle after reset, tick low
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		await_drained(1'b1);
		// reset values of the other registers
		set_regs(4'b0001, MODE_FOUR, 8'd0, 7'd0, 16'd0);
		send_tick(1'b1);
		send_tick(1'b1);
		await_drained(1'b1);
		// full scale, fastest phase step, then a tick low
		set_regs(4'b1111, MODE_FOUR, 8'd255, 7'd100, 16'd65535);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		await_drained(1'b1);
		// overmodulated pair, all quadrants
		set_regs(4'b1111, MODE_PAIR, 8'd4, 7'd127, 16'd40000);
		repeat (4) send_tick(1'b1);
		await_drained(1'b1);
		// zero top
		set_regs(4'b1000, MODE_PAIR, 8'd0, 7'd0, 16'd0);
		send_tick(1'b1);
		send_tick(1'b1);
		await_drained(1'b1);
		// counter wrap on a tiny period
		set_regs(4'b1111, MODE_FOUR, 8'd1, 7'd50, 16'd3);
		repeat (4) send_tick(1'b1);
		await_drained(1'b1);
		// the other idle mode
		set_regs(4'b0001, 2'd3, 8'd0, 7'd0, 16'd0);
		send_tick(1'b1);
		send_tick(1'b1);
		await_drained(1'b1);

		for (ph = 0; ph < PHASES; ph++) begin
			r = $urandom_range(9);
			m = (r < 4) ? MODE_FOUR : (r < 8) ? MODE_PAIR : (r == 8) ? 2'd0 : 2'd3;
			if (ph == 2 || ph == 4 || ph == 6) begin
				m = $urandom_range(1) ? MODE_FOUR : MODE_PAIR;
			end
			f = 8'(pick(0, 255));
			a = ($urandom_range(4) == 0) ? 7'(pick(101, 127)) : 7'(pick(0, 100));
			r = $urandom_range(9);
			t = (r < 4) ? 16'($urandom_range(64, 1)) : (r == 4) ? 16'd0 :
				(r == 5) ? 16'd65535 : 16'($urandom);
			set_regs(4'b1111, m, f, a, t);
			active = (m == MODE_FOUR || m == MODE_PAIR);
			calm = (ph == 4);
			sent = 0;
			counted = 0;
			while (counted < PHASE_WORDS && (active || sent < 8)) begin
				if (ph == 2 && sent == 10) begin
					hold_req = 1'b1;
				end
				if (ph == 6 && sent == 20) begin
					await_drained(1'b0);
				end
				tk = ($urandom_range(99) >= 10);
				sender_gap();
				send_tick(tk);
				sent++;
				if (tk && active) begin
					counted++;
				end
			end
			await_drained(1'b1);
		end
		calm = 1'b0;

		await_drained(1'b1);
		if (fails == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
